// ----- hdl/assert_macros.svh -----
// Assertion macros for the point-in-polygon RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define PIPC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pipc assertion failed");
// cons must hold in the cycle after ante
`define PIPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipc assertion failed");
`else
`define PIPC_ASSERT_ALWAYS(lbl, expr)
`define PIPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/pipc_pkg.sv -----
// Package: shared types and constants of the point-in-polygon crossing core
`default_nettype none
package pipc_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int COORD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    AXIS_YZ = 2'd0,
    AXIS_XZ = 2'd1,
    AXIS_XY = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    EDGE_SKIP  = 2'd0,
    EDGE_COUNT = 2'd1,
    EDGE_TEST  = 2'd2
  } edge_mode_t;

  typedef struct packed {
    logic first;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    edge_mode_t mode;
    logic       dy_neg;
  } edge_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/point_in_polygon_crossing_core.sv -----
// Top level: streaming point-in-polygon crossing-number core
//
// One polygon corner is taken per request, one every cycle while in_stall is
// low. A request passes an input register, an edge setup stage (projection,
// shift to the query point, edge classification), a product register holding
// the x0*dy and y0*dx products of both edges, and a parity stage; the result
// of a closing corner is loaded from the parity stage into the output register.
// The crossing parity is the only value carried from item to item at the end of
// the pipe, so it sets no limit on rate. There is no clearing pass after
// reset. A stalled result holds only the output register; the pipe behind it
// keeps moving until it meets another closing corner.
`default_nettype none
module point_in_polygon_crossing_core
  import pipc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [FIELD_BITS-1:0] point_x,
  input  logic signed [FIELD_BITS-1:0] point_y,
  input  logic signed [FIELD_BITS-1:0] point_z,
  input  logic signed [FIELD_BITS-1:0] normal_x,
  input  logic signed [FIELD_BITS-1:0] normal_y,
  input  logic signed [FIELD_BITS-1:0] normal_z,
  input  logic signed [FIELD_BITS-1:0] corner_x,
  input  logic signed [FIELD_BITS-1:0] corner_y,
  input  logic signed [FIELD_BITS-1:0] corner_z,
  input  logic                         first_corner,
  input  logic                         last_corner,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         inside_res
);

`include "assert_macros.svh"

  localparam int CW = COORD_BITS;
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;

  // input register
  logic                 v1;
  item_ctl_t            c1;
  logic signed [CW-1:0] px, py, pz, nx, ny, nz, cx, cy, cz;

  // polygon state
  axis_t                axis_choice;
  logic signed [CW-1:0] point_proj_u, point_proj_v;
  logic signed [CW-1:0] first_proj_u, first_proj_v;
  logic signed [CW-1:0] prev_proj_u, prev_proj_v;
  logic                 crossing_parity;

  // setup register
  logic                 v2;
  item_ctl_t            c2;
  logic signed [EW-1:0] e1_x0, e1_y0, e1_dx, e1_dy;
  logic signed [EW-1:0] e2_x0, e2_y0, e2_dx, e2_dy;
  edge_ctl_t            e1_ctl2, e2_ctl2;

  // product register
  logic                 v3;
  item_ctl_t            c3;
  logic signed [PW-1:0] e1_p, e1_q, e2_p, e2_q;
  edge_ctl_t            e1_ctl3, e2_ctl3;

  logic s1_ready, s2_ready, s3_ready, out_free;
  logic adv1, adv3, in_take;

  logic [CW-1:0]        ax, ay, az;
  axis_t                axis_new, axis_eff;
  logic signed [CW-1:0] pnew_u, pnew_v, cur_u, cur_v;
  logic signed [CW-1:0] pt_u, pt_v, fst_u, fst_v;
  logic signed [EW-1:0] s_e1_x0, s_e1_y0, s_e1_dx, s_e1_dy;
  logic signed [EW-1:0] s_e2_x0, s_e2_y0, s_e2_dx, s_e2_dy;
  edge_ctl_t            s_e1_ctl, s_e2_ctl;
  logic                 e1_cross, e2_cross;
  logic                 parity_next;

  // handshake
  always_comb begin
    out_free = !out_valid || !out_stall;
    s3_ready = !v3 || !c3.last || out_free;
    s2_ready = !v2 || s3_ready;
    s1_ready = !v1 || s2_ready;
    in_stall = !s1_ready;
    in_take  = in_valid && s1_ready;
    adv1     = v1 && s2_ready;
    adv3     = v3 && s3_ready;
  end

  // plane choice and projection
  always_comb begin
    ax = nx[CW-1] ? (~nx) + CW'(1) : nx;
    ay = ny[CW-1] ? (~ny) + CW'(1) : ny;
    az = nz[CW-1] ? (~nz) + CW'(1) : nz;
    if (ax >= ay && ax >= az) begin
      axis_new = AXIS_YZ;
    end else if (ay >= az) begin
      axis_new = AXIS_XZ;
    end else begin
      axis_new = AXIS_XY;
    end
    axis_eff = c1.first ? axis_new : axis_choice;
    case (axis_new)
      AXIS_YZ: begin pnew_u = py; pnew_v = pz; end
      AXIS_XZ: begin pnew_u = px; pnew_v = pz; end
      default: begin pnew_u = px; pnew_v = py; end
    endcase
    case (axis_eff)
      AXIS_YZ: begin cur_u = cy; cur_v = cz; end
      AXIS_XZ: begin cur_u = cx; cur_v = cz; end
      default: begin cur_u = cx; cur_v = cy; end
    endcase
    pt_u  = c1.first ? pnew_u : point_proj_u;
    pt_v  = c1.first ? pnew_v : point_proj_v;
    fst_u = c1.first ? cur_u : first_proj_u;
    fst_v = c1.first ? cur_v : first_proj_v;
  end

  pipc_edge_setup #(.COORD_BITS(COORD_BITS)) u_edge_prev (
    .from_u (prev_proj_u), .from_v (prev_proj_v),
    .to_u   (cur_u),       .to_v   (cur_v),
    .pt_u   (pt_u),        .pt_v   (pt_v),
    .x0     (s_e1_x0),     .y0     (s_e1_y0),
    .dx     (s_e1_dx),     .dy     (s_e1_dy),
    .ctl    (s_e1_ctl)
  );

  pipc_edge_setup #(.COORD_BITS(COORD_BITS)) u_edge_close (
    .from_u (cur_u),       .from_v (cur_v),
    .to_u   (fst_u),       .to_v   (fst_v),
    .pt_u   (pt_u),        .pt_v   (pt_v),
    .x0     (s_e2_x0),     .y0     (s_e2_y0),
    .dx     (s_e2_dx),     .dy     (s_e2_dy),
    .ctl    (s_e2_ctl)
  );

  pipc_cross_test #(.COORD_BITS(COORD_BITS)) u_cross_prev (
    .p (e1_p), .q (e1_q), .ctl (e1_ctl3), .crosses (e1_cross)
  );

  pipc_cross_test #(.COORD_BITS(COORD_BITS)) u_cross_close (
    .p (e2_p), .q (e2_q), .ctl (e2_ctl3), .crosses (e2_cross)
  );

  always_comb begin
    parity_next = (c3.first ? 1'b0 : crossing_parity) ^ e1_cross ^ e2_cross;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1              <= 1'b0;
      v2              <= 1'b0;
      v3              <= 1'b0;
      out_valid       <= 1'b0;
      axis_choice     <= AXIS_YZ;
      point_proj_u    <= '0;
      point_proj_v    <= '0;
      first_proj_u    <= '0;
      first_proj_v    <= '0;
      prev_proj_u     <= '0;
      prev_proj_v     <= '0;
      crossing_parity <= 1'b0;
    end else begin
      // input register
      if (s1_ready) begin
        v1 <= in_valid;
      end
      if (in_take) begin
        c1.first <= first_corner;
        c1.last  <= last_corner;
        px <= point_x[CW-1:0];
        py <= point_y[CW-1:0];
        pz <= point_z[CW-1:0];
        nx <= normal_x[CW-1:0];
        ny <= normal_y[CW-1:0];
        nz <= normal_z[CW-1:0];
        cx <= corner_x[CW-1:0];
        cy <= corner_y[CW-1:0];
        cz <= corner_z[CW-1:0];
      end
      // setup stage and polygon state
      if (s2_ready) begin
        v2 <= v1;
      end
      if (adv1) begin
        c2    <= c1;
        e1_x0 <= s_e1_x0;
        e1_y0 <= s_e1_y0;
        e1_dx <= s_e1_dx;
        e1_dy <= s_e1_dy;
        e2_x0 <= s_e2_x0;
        e2_y0 <= s_e2_y0;
        e2_dx <= s_e2_dx;
        e2_dy <= s_e2_dy;
        e1_ctl2.dy_neg <= s_e1_ctl.dy_neg;
        e1_ctl2.mode   <= c1.first ? EDGE_SKIP : s_e1_ctl.mode;
        e2_ctl2.dy_neg <= s_e2_ctl.dy_neg;
        e2_ctl2.mode   <= c1.last ? s_e2_ctl.mode : EDGE_SKIP;
        if (c1.first) begin
          axis_choice  <= axis_new;
          point_proj_u <= pnew_u;
          point_proj_v <= pnew_v;
          first_proj_u <= cur_u;
          first_proj_v <= cur_v;
        end
        prev_proj_u <= cur_u;
        prev_proj_v <= cur_v;
      end
      // product stage
      if (s3_ready) begin
        v3 <= v2;
      end
      if (v2 && s3_ready) begin
        c3      <= c2;
        e1_p    <= PW'(e1_x0) * PW'(e1_dy);
        e1_q    <= PW'(e1_y0) * PW'(e1_dx);
        e2_p    <= PW'(e2_x0) * PW'(e2_dy);
        e2_q    <= PW'(e2_y0) * PW'(e2_dx);
        e1_ctl3 <= e1_ctl2;
        e2_ctl3 <= e2_ctl2;
      end
      // parity stage and output register
      if (adv3) begin
        crossing_parity <= parity_next;
      end
      if (adv3 && c3.last) begin
        out_valid  <= 1'b1;
        inside_res <= parity_next;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PIPC_ASSERT_NEXT(a_result_loaded, adv3 && c3.last,
                    out_valid && (inside_res == $past(parity_next)))
  `PIPC_ASSERT_NEXT(a_first_clears, adv3 && c3.first && !c3.last,
                    !crossing_parity)
  `PIPC_ASSERT_ALWAYS(a_stall_only_full, !in_stall || (v1 && v2 && v3))
  `PIPC_ASSERT_ALWAYS(a_open_corner_flows, !(v3 && !c3.last) || s3_ready)

endmodule
`default_nettype wire

// ----- hdl/pipc_edge_setup.sv -----
// Edge setup: shift an edge to the query point and classify it
`default_nettype none
module pipc_edge_setup
  import pipc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] from_u,
  input  logic signed [COORD_BITS-1:0] from_v,
  input  logic signed [COORD_BITS-1:0] to_u,
  input  logic signed [COORD_BITS-1:0] to_v,
  input  logic signed [COORD_BITS-1:0] pt_u,
  input  logic signed [COORD_BITS-1:0] pt_v,
  output logic signed [COORD_BITS:0]   x0,
  output logic signed [COORD_BITS:0]   y0,
  output logic signed [COORD_BITS:0]   dx,
  output logic signed [COORD_BITS:0]   dy,
  output edge_ctl_t                    ctl
);

  localparam int EW = COORD_BITS + 1;

  logic signed [EW-1:0] x1;
  logic signed [EW-1:0] y1;
  logic y0_pos;
  logic y1_pos;

  always_comb begin
    x0 = EW'(from_u) - EW'(pt_u);
    y0 = EW'(from_v) - EW'(pt_v);
    x1 = EW'(to_u) - EW'(pt_u);
    y1 = EW'(to_v) - EW'(pt_v);
    dx = EW'(to_u) - EW'(from_u);
    dy = EW'(to_v) - EW'(from_v);
    y0_pos = !y0[EW-1] && (y0 != '0);
    y1_pos = !y1[EW-1] && (y1 != '0);
    ctl.dy_neg = dy[EW-1];
    if ((y0[EW-1] && y1[EW-1]) || (y0_pos && y1_pos) || (dy == '0) ||
        (x0[EW-1] && x1[EW-1])) begin
      ctl.mode = EDGE_SKIP;
    end else if (!x0[EW-1] && !x1[EW-1]) begin
      ctl.mode = EDGE_COUNT;
    end else begin
      ctl.mode = EDGE_TEST;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pipc_cross_test.sv -----
// Crossing decision from the registered edge products
`default_nettype none
module pipc_cross_test
  import pipc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [2*COORD_BITS+1:0] p,
  input  logic signed [2*COORD_BITS+1:0] q,
  input  edge_ctl_t                      ctl,
  output logic                           crosses
);

  localparam int DW = 2 * COORD_BITS + 3;

  logic signed [DW-1:0] diff;
  logic                 diff_pos;

  always_comb begin
    diff     = DW'(p) - DW'(q);
    diff_pos = !diff[DW-1] && (diff != '0);
    case (ctl.mode)
      EDGE_COUNT: crosses = 1'b1;
      EDGE_TEST:  crosses = (diff == '0) || (diff_pos == !ctl.dy_neg);
      default:    crosses = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ----- tb/pipc_checker.sv -----
// Checker for the point-in-polygon crossing core: predicts each inside result and compares
module pipc_checker
  import pipc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [FIELD_BITS-1:0] point_x,
  input  logic signed [FIELD_BITS-1:0] point_y,
  input  logic signed [FIELD_BITS-1:0] point_z,
  input  logic signed [FIELD_BITS-1:0] normal_x,
  input  logic signed [FIELD_BITS-1:0] normal_y,
  input  logic signed [FIELD_BITS-1:0] normal_z,
  input  logic signed [FIELD_BITS-1:0] corner_x,
  input  logic signed [FIELD_BITS-1:0] corner_y,
  input  logic signed [FIELD_BITS-1:0] corner_z,
  input  logic                         first_corner,
  input  logic                         last_corner,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         inside_res,
  output int                           fail_count,
  output int                           pending
);

  axis_t  drop_axis = AXIS_YZ;
  longint query_u = 0, query_v = 0;
  longint first_u = 0, first_v = 0;
  longint prev_u = 0, prev_v = 0;
  bit     parity = 1'b0;
  bit     inside_expected[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint coord(input logic [FIELD_BITS-1:0] f);
    logic signed [FIELD_BITS-1:0] t;
    t = f << (FIELD_BITS - COORD_BITS);
    t = t >>> (FIELD_BITS - COORD_BITS);
    return longint'(t);
  endfunction

  function automatic longint magnitude(input longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic void project(input axis_t ax, input longint x, input longint y,
                                  input longint z, output longint u, output longint v);
    case (ax)
      AXIS_YZ: begin
        u = y;
        v = z;
      end
      AXIS_XZ: begin
        u = x;
        v = z;
      end
      default: begin
        u = x;
        v = y;
      end
    endcase
  endfunction

  // edge shifted to the query point, tested against the non-negative x axis
  function automatic bit edge_crosses_ray(input longint fu, input longint fv,
                                          input longint tu, input longint tv);
    longint x0, y0, x1, y1, dx, dy;
    logic signed [127:0] wx0, wy0, wdx, wdy, side;
    x0 = fu - query_u;
    y0 = fv - query_v;
    x1 = tu - query_u;
    y1 = tv - query_v;
    dx = x1 - x0;
    dy = y1 - y0;
    if ((y0 < 0 && y1 < 0) || (y0 > 0 && y1 > 0) || dy == 0 || (x0 < 0 && x1 < 0))
      return 1'b0;
    if (x0 >= 0 && x1 >= 0)
      return 1'b1;
    wx0  = x0;
    wy0  = y0;
    wdx  = dx;
    wdy  = dy;
    side = wx0 * wdy - wy0 * wdx;
    return side == 0 || ((side > 0) == (dy > 0));
  endfunction

  always @(posedge clk) begin : predict
    longint cu, cv, nx, ny, nz;
    bit     want;
    if (rst) begin
      drop_axis = AXIS_YZ;
      query_u   = 0;
      query_v   = 0;
      first_u   = 0;
      first_v   = 0;
      prev_u    = 0;
      prev_v    = 0;
      parity    = 1'b0;
      inside_expected.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (inside_expected.size() == 0) begin
          fail_count++;
          $display("%0t pipc_checker: result with none expected, got inside_res=%0b",
                   $time, inside_res);
        end else begin
          want = inside_expected.pop_front();
          if (inside_res !== want) begin
            fail_count++;
            $display("%0t pipc_checker: inside_res expected %0b actual %0b",
                     $time, want, inside_res);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (first_corner) begin
          nx = magnitude(coord(normal_x));
          ny = magnitude(coord(normal_y));
          nz = magnitude(coord(normal_z));
          if (nx >= ny && nx >= nz)
            drop_axis = AXIS_YZ;
          else if (ny >= nz)
            drop_axis = AXIS_XZ;
          else
            drop_axis = AXIS_XY;
          project(drop_axis, coord(point_x), coord(point_y), coord(point_z),
                  query_u, query_v);
          project(drop_axis, coord(corner_x), coord(corner_y), coord(corner_z), cu, cv);
          first_u = cu;
          first_v = cv;
          parity  = 1'b0;
        end else begin
          project(drop_axis, coord(corner_x), coord(corner_y), coord(corner_z), cu, cv);
          if (edge_crosses_ray(prev_u, prev_v, cu, cv))
            parity = ~parity;
        end
        prev_u = cu;
        prev_v = cv;
        if (last_corner) begin
          if (edge_crosses_ray(cu, cv, first_u, first_v))
            parity = ~parity;
          inside_expected.push_back(parity);
        end
      end
    end
    pending = inside_expected.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the point-in-polygon crossing core: stimulus, idling and verdict
module tb;
  import pipc_pkg::*;

  localparam logic signed [FIELD_BITS-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [FIELD_BITS-1:0] MAXW = 32'sh7fff_ffff;
  localparam logic signed [FIELD_BITS-1:0] MINW = 32'sh8000_0000;
  localparam int RANDOM_CORNERS = 950;
  localparam int QUIET_LIMIT    = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FIELD_BITS-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [FIELD_BITS-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [FIELD_BITS-1:0] corner_x = '0, corner_y = '0, corner_z = '0;
  logic first_corner = 1'b0;
  logic last_corner = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic inside_res;

  bit idle_on = 1'b1;
  int fail_count, pending;
  int quiet_cycles = 0;
  int corners_sent = 0;
  int random_start, poly_no, n_corners;
  logic signed [FIELD_BITS-1:0] qp[3] = '{0, 0, 0};
  logic signed [FIELD_BITS-1:0] nv[3] = '{0, 0, 0};

  point_in_polygon_crossing_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .corner_z     (corner_z),
    .first_corner (first_corner),
    .last_corner  (last_corner),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .inside_res   (inside_res)
  );

  pipc_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .corner_z     (corner_z),
    .first_corner (first_corner),
    .last_corner  (last_corner),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .inside_res   (inside_res),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // point and normal only matter on a first corner; elsewhere they carry noise
  task automatic send_corner(input logic signed [FIELD_BITS-1:0] cx,
                             input logic signed [FIELD_BITS-1:0] cy,
                             input logic signed [FIELD_BITS-1:0] cz,
                             input bit f, input bit l);
    while (idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    point_x      <= f ? qp[0] : $urandom();
    point_y      <= f ? qp[1] : $urandom();
    point_z      <= f ? qp[2] : $urandom();
    normal_x     <= f ? nv[0] : $urandom();
    normal_y     <= f ? nv[1] : $urandom();
    normal_z     <= f ? nv[2] : $urandom();
    corner_x     <= cx;
    corner_y     <= cy;
    corner_z     <= cz;
    first_corner <= f;
    last_corner  <= l;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    corners_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [FIELD_BITS-1:0] flip(input logic signed [FIELD_BITS-1:0] v);
    return $urandom_range(1) ? -v : v;
  endfunction

  // mostly small whole steps from the point, so vertices land on the ray often
  function automatic logic signed [FIELD_BITS-1:0] near(input logic signed [FIELD_BITS-1:0] b);
    case ($urandom_range(9))
      0:             return b;
      1, 2, 3, 4, 5: return b + (int'($urandom_range(8)) - 4) * ONE;
      6, 7:          return b + int'($urandom_range(2097152)) - 1048576;
      8:             return $urandom();
      default:       return $urandom_range(1) ? MAXW : MINW;
    endcase
  endfunction

  task automatic pick_point();
    foreach (qp[i]) begin
      case ($urandom_range(3))
        0:       qp[i] = $urandom();
        1:       qp[i] = (int'($urandom_range(200)) - 100) * ONE;
        2:       qp[i] = $urandom_range(1) ? MAXW : MINW;
        default: qp[i] = int'($urandom_range(16)) - 8;
      endcase
    end
  endtask

  task automatic pick_normal();
    logic signed [FIELD_BITS-1:0] m;
    int k;
    m = $urandom() >> 1;
    k = $urandom_range(2);
    case ($urandom_range(5))
      0: foreach (nv[i]) nv[i] = $urandom();
      1: begin
        foreach (nv[i]) nv[i] = int'($urandom_range(2 * ONE)) - ONE;
        nv[k] = flip(8 * ONE);
      end
      2: begin
        nv[k]           = flip(m);
        nv[(k + 1) % 3] = flip(m);
        nv[(k + 2) % 3] = flip(m >>> 1);
      end
      3: foreach (nv[i]) nv[i] = '0;
      4: begin
        foreach (nv[i]) nv[i] = $urandom();
        nv[k] = MINW;
      end
      default: foreach (nv[i]) nv[i] = flip(m);
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // corners straight after reset, no first mark
    send_corner(ONE, -ONE, 2 * ONE, 1'b0, 1'b0);
    send_corner(-ONE, ONE, -ONE, 1'b0, 1'b1);

    // unit square around the point, xy plane
    qp = '{0, 0, 5 * ONE};
    nv = '{0, 0, ONE};
    send_corner(-ONE, -ONE, 0, 1'b1, 1'b0);
    send_corner(ONE, -ONE, 0, 1'b0, 1'b0);
    send_corner(ONE, ONE, 0, 1'b0, 1'b0);
    send_corner(-ONE, ONE, 0, 1'b0, 1'b1);

    // three-way normal tie, point lying on an edge
    qp = '{7, 10 * ONE, 10 * ONE};
    nv = '{3, 3, -3};
    send_corner(0, 0, 0, 1'b1, 1'b0);
    send_corner(0, 20 * ONE, 0, 1'b0, 1'b0);
    send_corner(0, 0, 20 * ONE, 1'b0, 1'b1);

    // y/z tie, vertex on the ray and a horizontal edge
    qp = '{0, 9 * ONE, 0};
    nv = '{ONE, -5 * ONE, 5 * ONE};
    send_corner(2 * ONE, 0, 0, 1'b1, 1'b0);
    send_corner(-ONE, 0, ONE, 1'b0, 1'b0);
    send_corner(-3 * ONE, 0, ONE, 1'b0, 1'b0);
    send_corner(-ONE, 0, -ONE, 1'b0, 1'b1);

    // full-scale coordinates
    qp = '{0, MAXW, MINW};
    nv = '{MINW, MAXW, 0};
    send_corner(0, MINW, MAXW, 1'b1, 1'b0);
    send_corner(0, MAXW, MAXW, 1'b0, 1'b0);
    send_corner(0, MAXW, MINW, 1'b0, 1'b0);
    send_corner(0, MINW, MINW, 1'b0, 1'b1);

    // single-corner polygon, then a stray closing corner
    send_corner(ONE, ONE, ONE, 1'b1, 1'b1);
    send_corner(-2 * ONE, ONE, 3 * ONE, 1'b0, 1'b1);
    drain();

    random_start = corners_sent;
    poly_no      = 0;
    while (corners_sent - random_start < RANDOM_CORNERS) begin
      poly_no++;
      idle_on <= !(poly_no >= 40 && poly_no < 75);
      if (poly_no % 70 == 0)
        drain();
      if ($urandom_range(9) == 0) begin
        foreach (qp[i]) qp[i] = $urandom();
        foreach (nv[i]) nv[i] = $urandom();
        send_corner($urandom(), $urandom(), $urandom(), $urandom_range(1), $urandom_range(1));
      end else begin
        n_corners = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(6, 3);
        pick_point();
        pick_normal();
        for (int k = 0; k < n_corners; k++)
          send_corner(near(qp[0]), near(qp[1]), near(qp[2]), k == 0, k == n_corners - 1);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/pipc_pkg.sv
hdl/pipc_edge_setup.sv
hdl/pipc_cross_test.sv
hdl/point_in_polygon_crossing_core.sv
tb/pipc_checker.sv
tb/tb.sv
